// File: hw/rtl/bat_pkg.sv
// shared types and constants for the breakpoint address table
`timescale 1ns / 1ps
package bat_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int MAX_ENTRIES     = 256;
  localparam int LIST_COUNT      = 3;
  localparam int ADDR_W          = 32;
  localparam int IDX_OUT_W       = 4;
  localparam int LIST_W          = 2;
  localparam int OP_W            = 2;
  localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 8;

  typedef logic [LIST_W-1:0] list_sel_t;

  localparam list_sel_t LIST_READ  = 2'd0;
  localparam list_sel_t LIST_WRITE = 2'd1;
  localparam list_sel_t LIST_EXEC  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    list_sel_t         list;
    logic              add_en;
    logic              shift_en;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  pos;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/bat_cell.sv
// one table position: holds entry IDX of each list, compares and shifts
`timescale 1ns / 1ps
module bat_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  bat_pkg::cell_ctrl_t       ctrl,
  input  logic [bat_pkg::ADDR_W-1:0] nb_in,
  output logic [bat_pkg::ADDR_W-1:0] sel_out,
  output logic                      match
);
  import bat_pkg::*;

  logic [ADDR_W-1:0] entry [LIST_COUNT];
  logic              occupied;

  always_comb begin
    case (ctrl.list)
      LIST_READ:  sel_out = entry[0];
      LIST_WRITE: sel_out = entry[1];
      LIST_EXEC:  sel_out = entry[2];
      default:    sel_out = '0;
    endcase
  end

  assign occupied = CNT_W'(IDX) < ctrl.count;
  assign match    = occupied && (sel_out == ctrl.addr);

  // append lands at the position equal to the count; remove pulls from the right neighbor
  always_ff @(posedge clk) begin
    if (ctrl.add_en && (CNT_W'(IDX) == ctrl.count)) begin
      entry[ctrl.list] <= ctrl.addr;
    end else if (ctrl.shift_en && (CNT_W'(IDX) >= ctrl.pos)) begin
      entry[ctrl.list] <= nb_in;
    end
  end

endmodule

// File: hw/rtl/breakpoint_address_table_unit.sv
// Breakpoint address table: three ordered address lists held in a row of cells.
// Each cell holds one position of all three lists and compares it against the
// beat's address in parallel; removal shifts later entries down one cell. One
// beat is worked on at a time and gives one result beat. Add, clear and beats
// naming list 3 go from acceptance straight to the done state; lookup and
// remove first register the match vector, then scan it eight cells per cycle
// (all cells when fewer than eight) for the first hit, ending early once
// found. A new beat is taken as soon as the result is in the output register,
// even if that result is still waiting. The result field match_index carries
// the low 4 bits of the first match position.
`timescale 1ns / 1ps
module breakpoint_address_table_unit #(
  parameter int ENTRIES_PER_LIST = bat_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // opcode[1:0], list_kind[3:2], bp_address[35:4], zero fill
  input  logic [bat_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // hit[0], match_index[4:1], full_res[5], zero fill
  output logic [bat_pkg::OUT_DATA_W-1:0] m_tdata
);
  import bat_pkg::*;

  localparam int N   = ENTRIES_PER_LIST;
  localparam int CW  = $clog2(N + 1);
  localparam int PW  = (N > 1) ? $clog2(N) : 1;
  localparam int GW  = (N < 8) ? N : 8;
  localparam int NG  = (N + GW - 1) / GW;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int LW  = (GW > 1) ? $clog2(GW) : 1;

  state_t state, state_next;

  op_t               op;
  list_sel_t         list;
  logic [ADDR_W-1:0] addr;
  logic [CW-1:0]     cnt [LIST_COUNT];
  logic [CW-1:0]     cnt_sel;
  logic              list_ok;

  logic [N-1:0]      match_vec;
  logic [N-1:0]      match_q;
  logic [NG*GW-1:0]  match_pad;
  logic [GW-1:0]     grp_bits;
  logic [GIW-1:0]    grp;
  logic [LW-1:0]     low;
  logic              any;
  logic              found;
  logic [PW-1:0]     pos;

  logic              accept;
  logic              commit;
  logic              r_hit;
  logic              r_full;
  logic              add_ok;

  logic [ADDR_W-1:0] sel_bus [N];
  cell_ctrl_t        ctrl;

  assign accept  = s_tvalid && s_tready;
  assign list_ok = list <= LIST_EXEC;

  always_comb begin
    case (list)
      LIST_READ:  cnt_sel = cnt[0];
      LIST_WRITE: cnt_sel = cnt[1];
      LIST_EXEC:  cnt_sel = cnt[2];
      default:    cnt_sel = '0;
    endcase
  end

  assign add_ok = cnt_sel < CW'(N);
  assign r_full = list_ok && (op == OP_ADD) && !add_ok;
  assign r_hit  = found;

  always_comb begin
    ctrl          = '0;
    ctrl.list     = list;
    ctrl.addr     = addr;
    ctrl.count    = CNT_W'(cnt_sel);
    ctrl.pos      = CNT_W'(pos);
    ctrl.add_en   = commit && list_ok && (op == OP_ADD) && add_ok;
    ctrl.shift_en = commit && (op == OP_REMOVE) && found;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [ADDR_W-1:0] nb;
    if (i == N - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_link
      assign nb = sel_bus[i+1];
    end
    bat_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .nb_in   (nb),
      .sel_out (sel_bus[i]),
      .match   (match_vec[i])
    );
  end

  // scan one group of the registered match vector per cycle
  assign match_pad = (NG*GW)'(match_q);
  assign grp_bits  = match_pad[grp*GW +: GW];
  assign any       = |grp_bits;

  always_comb begin
    low = '0;
    for (int j = GW - 1; j >= 0; j--) begin
      if (grp_bits[j]) begin
        low = LW'(j);
      end
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if ((s_tdata[1:0] == OP_REMOVE || s_tdata[1:0] == OP_LOOKUP)
              && (s_tdata[3:2] <= LIST_EXEC)) begin
            state_next = ST_CMP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CMP: state_next = ST_SCAN;
      ST_SCAN: begin
        if (any || (grp == GIW'(NG - 1))) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_t'(s_tdata[1:0]);
      list <= s_tdata[3:2];
      addr <= s_tdata[35:4];
    end
    if (state == ST_CMP) begin
      match_q <= match_vec;
    end
    if (state == ST_SCAN && any) begin
      pos <= PW'(int'(grp) * GW + int'(low));
    end else if (accept) begin
      pos <= '0;
    end
    if (commit) begin
      m_tdata <= OUT_DATA_W'({r_full, IDX_OUT_W'(found ? pos : '0), r_hit});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      grp      <= '0;
      m_tvalid <= 1'b0;
      for (int k = 0; k < LIST_COUNT; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      if (accept) begin
        found <= 1'b0;
        grp   <= '0;
      end else if (state == ST_SCAN) begin
        if (any) begin
          found <= 1'b1;
        end else if (grp != GIW'(NG - 1)) begin
          grp <= grp + 1'b1;
        end
      end
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (commit && list_ok) begin
        case (op)
          OP_ADD:    if (add_ok) cnt[list] <= cnt_sel + 1'b1;
          OP_REMOVE: if (found) cnt[list] <= cnt_sel - 1'b1;
          OP_CLEAR:  cnt[list] <= '0;
          default:   ;
        endcase
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= CW'(N)) && (cnt[1] <= CW'(N)) && (cnt[2] <= CW'(N)))
    else $error("list count above capacity");

  a_hit_full_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[5]))
    else $error("result with both hit and full");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift_en |-> (CW'(pos) < cnt_sel))
    else $error("remove position past list end");

  a_found_only_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && found) |-> (op == OP_REMOVE || op == OP_LOOKUP))
    else $error("hit recorded for an add or clear");

endmodule
